### hw/rtl/efs_pkg.sv
// ----------------------------------------------------------------------------
// efs_pkg
// Types, codes and the sequencer program of the event angle floor search.
// ----------------------------------------------------------------------------
package efs_pkg;

  // field widths of the configuration, item and result channels
  localparam int unsigned ANGLE_W = 17;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned CFG_IDX_W = 1;

  // item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RISING_ONLY = 1'b1;

  // configuration reset values
  localparam logic [COUNT_W-1:0] EVENT_COUNT_RST = 10'd1;
  localparam logic               RISING_ONLY_RST = 1'b0;

  // program steps
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_PROBE,
    ST_DONE
  } step_e;

  // jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_QUERY,
    C_RANGE,
    C_RANGE_NX,
    C_OUT_FREE
  } cond_e;

  // table read address source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_CUR,
    RD_NEXT
  } rd_e;

  // one control word
  typedef struct packed {
    logic  in_ready;
    logic  upd_bounds;
    logic  out_load;
    rd_e   rd_sel;
    cond_e cond;
    step_e jmp_t;
    step_e jmp_f;
  } uword_t;

  // sequencer program: one control word per step
  function automatic uword_t ucode(step_e s);
    uword_t w;
    w = '{in_ready: 1'b0, upd_bounds: 1'b0, out_load: 1'b0, rd_sel: RD_NONE,
          cond: C_ALWAYS, jmp_t: ST_IDLE, jmp_f: ST_IDLE};
    case (s)
      // take items, a query starts the search
      ST_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = C_QUERY;
        w.jmp_t    = ST_START;
        w.jmp_f    = ST_IDLE;
      end
      // first probe, or nothing to search
      ST_START: begin
        w.rd_sel = RD_CUR;
        w.cond   = C_RANGE;
        w.jmp_t  = ST_PROBE;
        w.jmp_f  = ST_DONE;
      end
      // compare, narrow the interval, issue the next probe
      ST_PROBE: begin
        w.upd_bounds = 1'b1;
        w.rd_sel     = RD_NEXT;
        w.cond       = C_RANGE_NX;
        w.jmp_t      = ST_PROBE;
        w.jmp_f      = ST_DONE;
      end
      // hand the result to the output register once it is free
      ST_DONE: begin
        w.out_load = 1'b1;
        w.cond     = C_OUT_FREE;
        w.jmp_t    = ST_IDLE;
        w.jmp_f    = ST_DONE;
      end
      default: begin
        w.jmp_t = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/efs_if.sv
// ----------------------------------------------------------------------------
// efs channel interfaces
// Valid/ready channels for configuration writes, input items and results.
// ----------------------------------------------------------------------------
interface efs_cfg_if import efs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COUNT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface efs_in_if import efs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [IDX_W-1:0]   entry_index;
  logic [ANGLE_W-1:0] angle_value;

  modport source (output valid, op, entry_index, angle_value, input ready);
  modport sink   (input valid, op, entry_index, angle_value, output ready);
endinterface

interface efs_out_if import efs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] found_index;
  logic             found;

  modport source (output valid, found_index, found, input ready);
  modport sink   (input valid, found_index, found, output ready);
endinterface

### hw/rtl/efs_ram.sv
// ----------------------------------------------------------------------------
// efs_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module efs_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/event_angle_floor_search_top.sv
// ----------------------------------------------------------------------------
// event_angle_floor_search_top
// Angle table with a binary search for the last entry at or below a target.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  cfg_i    in   valid/ready    index, data (event_count, rising_only)
//  in_i     in   valid/ready    op, entry_index, angle_value
//  out_o    out  valid/ready    found_index, found (one per query item)
//
//  a write item is taken in the idle step and gives no result
//  a query item passes the start step, p probe steps and the done step, p at most
//  ceil(log2(count + 1)), with one table read per probe on the RAM read port
//  reset clears the sequencer and config; the table is not cleared
//  a waiting result does not block the next item; a new result waits in
//  the done step until the output register is free
module event_angle_floor_search_top import efs_pkg::*; #(
  parameter int unsigned MAX_EVENTS = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  efs_cfg_if.sink   cfg_i,
  efs_in_if.sink    in_i,
  efs_out_if.source out_o
);

  localparam int unsigned AW = $clog2(MAX_EVENTS);
  localparam int unsigned CW = $clog2(MAX_EVENTS + 1);
  localparam int unsigned SW = (CW > COUNT_W) ? CW : COUNT_W;

  // configuration registers
  logic [COUNT_W-1:0] cnt_q;
  logic               rising_q;

  // sequencer and datapath
  step_e              step_q, step_d;
  uword_t             uw;
  logic               cond_true;
  logic [CW-1:0]      lo_q, hi_q, mid_q;
  logic [CW-1:0]      lo_nx, hi_nx, mid_cur, mid_nx, rd_mid, n_sat;
  logic [CW:0]        sum_cur, sum_nx;
  logic [ANGLE_W-1:0] tgt_q;
  logic [ANGLE_W-1:0] rdata;
  logic               cmp_le;
  logic               in_acc, query_acc, write_acc, out_free;
  logic               ram_we, ram_re;

  // result register
  logic               out_valid_q;
  logic [IDX_W-1:0]   found_index_q, res_idx;
  logic               found_q, res_found;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= EVENT_COUNT_RST;
      rising_q <= RISING_ONLY_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_EVENT_COUNT: cnt_q    <= cfg_i.data;
        REG_RISING_ONLY: rising_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // count limited to the table depth
  assign n_sat = (SW'(cnt_q) > SW'(MAX_EVENTS)) ? CW'(MAX_EVENTS) : CW'(cnt_q);

  // input handshake
  assign uw        = ucode(step_q);
  assign in_i.ready = uw.in_ready;
  assign in_acc    = in_i.valid && uw.in_ready;
  assign query_acc = in_acc && (in_i.op == OP_QUERY);
  assign write_acc = in_acc && (in_i.op == OP_WRITE);
  assign out_free  = !out_valid_q || out_o.ready;

  // interval arithmetic: mid of [lo, hi - 1], rounded down
  assign sum_cur = {1'b0, lo_q} + {1'b0, hi_q} - (CW+1)'(1);
  assign mid_cur = sum_cur[CW:1];
  assign cmp_le  = (rdata <= tgt_q);
  assign lo_nx   = cmp_le ? (mid_q + CW'(1)) : lo_q;
  assign hi_nx   = cmp_le ? hi_q : mid_q;
  assign sum_nx  = {1'b0, lo_nx} + {1'b0, hi_nx} - (CW+1)'(1);
  assign mid_nx  = sum_nx[CW:1];
  assign rd_mid  = (uw.rd_sel == RD_NEXT) ? mid_nx : mid_cur;

  // condition select and next step
  always_comb begin
    case (uw.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_QUERY:    cond_true = query_acc;
      C_RANGE:    cond_true = (lo_q < hi_q);
      C_RANGE_NX: cond_true = (lo_nx < hi_nx);
      C_OUT_FREE: cond_true = out_free;
      default:    cond_true = 1'b0;
    endcase
    step_d = cond_true ? uw.jmp_t : uw.jmp_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // search registers
  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      lo_q  <= '0;
      hi_q  <= n_sat;
      tgt_q <= in_i.angle_value;
    end else if (uw.upd_bounds) begin
      lo_q <= lo_nx;
      hi_q <= hi_nx;
    end
    if (ram_re) begin
      mid_q <= rd_mid;
    end
  end

  // angle table
  assign ram_we = write_acc && (32'(in_i.entry_index) < MAX_EVENTS);
  assign ram_re = (uw.rd_sel != RD_NONE) && cond_true;

  efs_ram #(
    .WIDTH (ANGLE_W),
    .DEPTH (MAX_EVENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_i.entry_index)),
    .wdata_i (in_i.angle_value),
    .re_i    (ram_re),
    .raddr_i (AW'(rd_mid)),
    .rdata_o (rdata)
  );

  // result: last qualifying index is lo - 1, with bit 0 cleared when rising_only is set
  assign res_found = (lo_q != '0);
  always_comb begin
    res_idx = '0;
    if (res_found) begin
      res_idx = IDX_W'(lo_q - CW'(1));
      if (rising_q) begin
        res_idx[0] = 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.out_load && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.out_load && out_free) begin
      found_index_q <= res_idx;
      found_q       <= res_found;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found_index = found_index_q;
  assign out_o.found       = found_q;

  // interval stays ordered while a search runs
  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != ST_IDLE) |-> (lo_q <= hi_q))
    else $error("search interval inverted");

  // the probed entry lies inside the half-open interval [lo, hi)
  a_mid_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_PROBE) |-> ((mid_q >= lo_q) && (mid_q < hi_q)))
    else $error("probe outside interval");

  // upper bound never passes the searched count
  a_hi_within_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != ST_IDLE) |-> (hi_q <= n_sat))
    else $error("upper bound beyond count");

  // a result is held back while the previous one is still waiting
  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((step_q == ST_DONE) && out_valid_q && !out_o.ready) |=> (step_q == ST_DONE))
    else $error("result overwrote a waiting item");

endmodule
